FILE: sv/uvs_pkg.sv
// Shared types, constants and helper function of the UV sphere tessellator.
`default_nettype none
package uvs_pkg;

   localparam int GRID_MAX      = 256;
   localparam int FRACTION_BITS = 15;
   localparam int NRM_SHIFT     = 30 - FRACTION_BITS;
   localparam int TERMS         = 6;
   localparam int TERM_W        = $clog2(TERMS);
   localparam int DIV_STEPS     = 17;
   localparam int STAGE_STEPS   = 6;
   localparam int LAST_STEPS    = DIV_STEPS - 2 * STAGE_STEPS;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [31:0] PI_Q30 = 32'd3373259426;

   // reciprocal multipliers ceil(2^k / d) for the series term divisors
   localparam logic [30:0] SIN_RECIP [TERMS] = '{
      31'(((64'd1 << 33) + 64'd5)   / 64'd6),
      31'(((64'd1 << 35) + 64'd19)  / 64'd20),
      31'(((64'd1 << 36) + 64'd41)  / 64'd42),
      31'(((64'd1 << 37) + 64'd71)  / 64'd72),
      31'(((64'd1 << 37) + 64'd109) / 64'd110),
      31'(((64'd1 << 38) + 64'd155) / 64'd156)
   };
   localparam int SIN_SHIFT [TERMS] = '{33, 35, 36, 37, 37, 38};

   localparam logic [30:0] COS_RECIP [TERMS] = '{
      31'(((64'd1 << 31) + 64'd1)   / 64'd2),
      31'(((64'd1 << 34) + 64'd11)  / 64'd12),
      31'(((64'd1 << 35) + 64'd29)  / 64'd30),
      31'(((64'd1 << 36) + 64'd55)  / 64'd56),
      31'(((64'd1 << 37) + 64'd89)  / 64'd90),
      31'(((64'd1 << 38) + 64'd131) / 64'd132)
   };
   localparam int COS_SHIFT [TERMS] = '{31, 34, 35, 36, 37, 38};

   localparam logic [1:0] KIND_POS = 2'd0;
   localparam logic [1:0] KIND_NRM = 2'd1;
   localparam logic [1:0] KIND_TRI = 2'd2;

   localparam logic [1:0] OUT_POS   = 2'd0;
   localparam logic [1:0] OUT_NRM   = 2'd1;
   localparam logic [1:0] OUT_TRI_A = 2'd2;
   localparam logic [1:0] OUT_TRI_B = 2'd3;

   localparam logic [1:0] CSR_RING_COUNT   = 2'd0;
   localparam logic [1:0] CSR_SECTOR_COUNT = 2'd1;
   localparam logic [1:0] CSR_RADIUS       = 2'd2;

   typedef struct packed {
      logic [7:0]  rem;
      logic [16:0] num;
      logic [16:0] quo;
   } uvs_div_type;

   typedef struct packed {
      logic [16:0] tex_u;
      logic [16:0] tex_v;
      logic [15:0] i00;
      logic [15:0] i01;
      logic [15:0] i10;
      logic [15:0] i11;
      logic        tris;
   } uvs_item_type;

   typedef struct packed {
      logic [16:0] pos_x;
      logic [16:0] pos_y;
      logic [16:0] pos_z;
      logic [16:0] nrm_x;
      logic [16:0] nrm_y;
      logic [16:0] nrm_z;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
      logic [15:0] i00;
      logic [15:0] i01;
      logic [15:0] i10;
      logic [15:0] i11;
      logic        tris;
   } uvs_result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ANGLE,
      BK_SQUARE,
      BK_MUL,
      BK_DIV,
      BK_NORM,
      BK_SCALE
   } uvs_back_state_type;

   function automatic logic [8:0] clamp_count(input logic [8:0] c);
      if (c < 9'd2) begin
         return 9'd2;
      end
      if (c > 9'(GRID_MAX)) begin
         return 9'(GRID_MAX);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: sv/uvs_front.sv
// Front end: range check, triangle indices and pipelined u/v division.
`default_nettype none
module uvs_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [15:0]         req_tdata,   // ring_index, sector_index
   input  wire logic [8:0]          ring_count,
   input  wire logic [8:0]          sector_count,
   output uvs_pkg::uvs_item_type    item,
   output logic                     item_valid,
   input  wire logic                item_ready
);

   function automatic uvs_pkg::uvs_div_type div_step(input uvs_pkg::uvs_div_type st,
                                                     input logic [7:0] d);
      logic [8:0]           t;
      logic                 ge;
      uvs_pkg::uvs_div_type nx;
      t  = {st.rem, st.num[16]};
      ge = t >= {1'b0, d};
      nx.rem = ge ? 8'(t - {1'b0, d}) : t[7:0];
      nx.num = {st.num[15:0], 1'b0};
      nx.quo = {st.quo[15:0], ge};
      return nx;
   endfunction

   logic [8:0]  rc, sc;
   logic [7:0]  r, s, du, dv;
   logic [23:0] nu, nv;
   logic        in_grid, en;
   logic [16:0] prod;
   uvs_pkg::uvs_item_type pay;
   uvs_pkg::uvs_div_type  a_u, a_v, b_u, b_v, c_u, c_v;

   logic                  s1_v_ff, s2_v_ff, s3_v_ff;
   uvs_pkg::uvs_div_type  s1_u_ff, s1_w_ff, s2_u_ff, s2_w_ff;
   logic [7:0]            s1_du_ff, s1_dv_ff, s2_du_ff, s2_dv_ff;
   uvs_pkg::uvs_item_type s1_pay_ff, s2_pay_ff, s3_item_ff;
   uvs_pkg::uvs_item_type s3_item_in;

   always_comb begin
      rc = uvs_pkg::clamp_count(ring_count);
      sc = uvs_pkg::clamp_count(sector_count);
      r  = req_tdata[7:0];
      s  = req_tdata[15:8];
      in_grid = ({1'b0, r} < rc) && ({1'b0, s} < sc);
      du = 8'(sc - 9'd1);
      dv = 8'(rc - 9'd1);
      nu = {s, 16'b0} + {17'b0, du[7:1]};
      nv = {r, 16'b0} + {17'b0, dv[7:1]};
      a_u.rem = {1'b0, nu[23:17]};
      a_u.num = nu[16:0];
      a_u.quo = '0;
      a_v.rem = {1'b0, nv[23:17]};
      a_v.num = nv[16:0];
      a_v.quo = '0;
      for (int i = 0; i < uvs_pkg::STAGE_STEPS; i++) begin
         a_u = div_step(a_u, du);
         a_v = div_step(a_v, dv);
      end
      prod     = r * sc;
      pay.i00  = 16'(prod + {9'b0, s});
      pay.i01  = pay.i00 + 16'd1;
      pay.i10  = pay.i00 + {7'b0, sc};
      pay.i11  = pay.i10 + 16'd1;
      pay.tris = ({1'b0, r} < rc - 9'd1) && ({1'b0, s} < sc - 9'd1);
      pay.tex_u = '0;
      pay.tex_v = '0;
      b_u = s1_u_ff;
      b_v = s1_w_ff;
      for (int i = 0; i < uvs_pkg::STAGE_STEPS; i++) begin
         b_u = div_step(b_u, s1_du_ff);
         b_v = div_step(b_v, s1_dv_ff);
      end
      c_u = s2_u_ff;
      c_v = s2_w_ff;
      for (int i = 0; i < uvs_pkg::LAST_STEPS; i++) begin
         c_u = div_step(c_u, s2_du_ff);
         c_v = div_step(c_v, s2_dv_ff);
      end
      s3_item_in       = s2_pay_ff;
      s3_item_in.tex_u = c_u.quo;
      s3_item_in.tex_v = c_v.quo;
   end

   assign en         = !s3_v_ff || item_ready;
   assign req_tready = en;
   assign item       = s3_item_ff;
   assign item_valid = s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid && in_grid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_u_ff    <= a_u;
         s1_w_ff    <= a_v;
         s1_du_ff   <= du;
         s1_dv_ff   <= dv;
         s1_pay_ff  <= pay;
         s2_u_ff    <= b_u;
         s2_w_ff    <= b_v;
         s2_du_ff   <= s1_du_ff;
         s2_dv_ff   <= s1_dv_ff;
         s2_pay_ff  <= s1_pay_ff;
         s3_item_ff <= s3_item_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/uvs_queue.sv
// Short item queue between the front end and the back end.
`default_nettype none
module uvs_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire uvs_pkg::uvs_item_type in_item,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   output uvs_pkg::uvs_item_type      out_item,
   output logic                       out_valid,
   input  wire logic                  out_ready
);

   localparam int PTR_W = $clog2(uvs_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(uvs_pkg::QUEUE_DEPTH + 1);

   uvs_pkg::uvs_item_type mem_ff [uvs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign in_ready  = count_ff < CNT_W'(uvs_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

FILE: sv/uvs_back.sv
// Back end: iterative sine/cosine series, normal and scaled position.
`default_nettype none
module uvs_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire uvs_pkg::uvs_item_type q_item,
   input  wire logic                  q_valid,
   output logic                       q_ready,
   input  wire logic [15:0]           radius,
   output uvs_pkg::uvs_result_type    res,
   output logic                       res_valid,
   input  wire logic                  res_ready
);

   function automatic logic [16:0] to_code(input logic neg, input logic [31:0] m);
      logic [15:0] v;
      v = (m > 32'd65535) ? 16'hFFFF : m[15:0];
      return neg ? 17'(17'd0 - {1'b0, v}) : {1'b0, v};
   endfunction

   uvs_pkg::uvs_back_state_type state_ff, state_in;
   logic [uvs_pkg::TERM_W-1:0]  term_ff, term_in;
   uvs_pkg::uvs_item_type       item_ff, item_in;

   logic [1:0]  quad_ff [2], quad_in [2];
   logic        swap_ff [2], swap_in [2];
   logic [29:0] x2_ff [2], x2_in [2];
   logic [29:0] ts_ff [2], ts_in [2];
   logic [30:0] tc_ff [2], tc_in [2];
   logic [29:0] ps_ff [2], ps_in [2];
   logic [29:0] pc_ff [2], pc_in [2];
   logic [30:0] sn_ff [2], sn_in [2];
   logic [30:0] cs_ff [2], cs_in [2];
   logic [30:0] nm_ff [3], nm_in [3];
   logic        nn_ff [3], nn_in [3];

   logic [31:0] ph;
   logic [29:0] f, g;
   logic [63:0] wide;
   logic [30:0] sfm, cfm;
   logic [30:0] sin_m [2], cos_m [2];
   logic        sin_n [2], cos_n [2];
   logic [46:0] pm;
   logic [31:0] nr;
   logic [16:0] pos_c [3], nrm_c [3];
   logic        take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uvs_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      item_ff <= item_in;
      quad_ff <= quad_in;
      swap_ff <= swap_in;
      x2_ff   <= x2_in;
      ts_ff   <= ts_in;
      tc_ff   <= tc_in;
      ps_ff   <= ps_in;
      pc_ff   <= pc_in;
      sn_ff   <= sn_in;
      cs_ff   <= cs_in;
      nm_ff   <= nm_in;
      nn_ff   <= nn_in;
   end

   // final sine/cosine after octant swap and quadrant mapping
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         sfm = swap_ff[l] ? cs_ff[l] : sn_ff[l];
         cfm = swap_ff[l] ? sn_ff[l] : cs_ff[l];
         case (quad_ff[l])
            2'd0: begin
               sin_m[l] = sfm; sin_n[l] = 1'b0; cos_m[l] = cfm; cos_n[l] = 1'b0;
            end
            2'd1: begin
               sin_m[l] = cfm; sin_n[l] = 1'b0; cos_m[l] = sfm; cos_n[l] = 1'b1;
            end
            2'd2: begin
               sin_m[l] = sfm; sin_n[l] = 1'b1; cos_m[l] = cfm; cos_n[l] = 1'b1;
            end
            default: begin
               sin_m[l] = cfm; sin_n[l] = 1'b1; cos_m[l] = sfm; cos_n[l] = 1'b0;
            end
         endcase
      end
      for (int a = 0; a < 3; a++) begin
         pm = nm_ff[a] * radius;
         pm = pm + 47'(64'd1 << 29);
         pos_c[a] = to_code(nn_ff[a], {15'b0, pm[46:30]});
         nr = {1'b0, nm_ff[a]} + 32'(64'd1 << (uvs_pkg::NRM_SHIFT - 1));
         nrm_c[a] = to_code(nn_ff[a], nr >> uvs_pkg::NRM_SHIFT);
      end
      res.pos_x = pos_c[0];
      res.pos_y = pos_c[1];
      res.pos_z = pos_c[2];
      res.nrm_x = nrm_c[0];
      res.nrm_y = nrm_c[1];
      res.nrm_z = nrm_c[2];
      res.tex_u = item_ff.tex_u;
      res.tex_v = item_ff.tex_v;
      res.i00   = item_ff.i00;
      res.i01   = item_ff.i01;
      res.i10   = item_ff.i10;
      res.i11   = item_ff.i11;
      res.tris  = item_ff.tris;
   end

   assign res_valid = state_ff == uvs_pkg::BK_SCALE;

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      item_in  = item_ff;
      quad_in  = quad_ff;
      swap_in  = swap_ff;
      x2_in    = x2_ff;
      ts_in    = ts_ff;
      tc_in    = tc_ff;
      ps_in    = ps_ff;
      pc_in    = pc_ff;
      sn_in    = sn_ff;
      cs_in    = cs_ff;
      nm_in    = nm_ff;
      nn_in    = nn_ff;
      q_ready  = 1'b0;
      take     = 1'b0;
      ph       = '0;
      f        = '0;
      g        = '0;
      wide     = '0;
      case (state_ff)
         uvs_pkg::BK_IDLE: begin
            take = 1'b1;
         end
         uvs_pkg::BK_ANGLE: begin
            for (int l = 0; l < 2; l++) begin
               ph = (l == 0) ? {item_ff.tex_v[16:0], 15'b0} : {item_ff.tex_u[15:0], 16'b0};
               f  = ph[29:0];
               swap_in[l] = f > 30'(64'd1 << 29);
               g  = swap_in[l] ? 30'((64'd1 << 30) - {34'b0, f}) : f;
               quad_in[l] = ph[31:30];
               wide = g * uvs_pkg::PI_Q30;
               wide = wide + (64'd1 << 30);
               ts_in[l] = wide[60:31];
               sn_in[l] = {1'b0, wide[60:31]};
               tc_in[l] = 31'(64'd1 << 30);
               cs_in[l] = 31'(64'd1 << 30);
            end
            state_in = uvs_pkg::BK_SQUARE;
         end
         uvs_pkg::BK_SQUARE: begin
            for (int l = 0; l < 2; l++) begin
               wide = ts_ff[l] * ts_ff[l];
               wide = wide + (64'd1 << 29);
               x2_in[l] = wide[59:30];
            end
            term_in  = '0;
            state_in = uvs_pkg::BK_MUL;
         end
         uvs_pkg::BK_MUL: begin
            for (int l = 0; l < 2; l++) begin
               wide = ts_ff[l] * x2_ff[l];
               wide = wide + (64'd1 << 29);
               ps_in[l] = wide[59:30];
               wide = tc_ff[l] * x2_ff[l];
               wide = wide + (64'd1 << 29);
               pc_in[l] = wide[59:30];
            end
            state_in = uvs_pkg::BK_DIV;
         end
         uvs_pkg::BK_DIV: begin
            for (int l = 0; l < 2; l++) begin
               wide = ps_ff[l] * uvs_pkg::SIN_RECIP[term_ff];
               wide = wide >> uvs_pkg::SIN_SHIFT[term_ff];
               ts_in[l] = wide[29:0];
               sn_in[l] = term_ff[0] ? sn_ff[l] + {1'b0, wide[29:0]}
                                     : sn_ff[l] - {1'b0, wide[29:0]};
               wide = pc_ff[l] * uvs_pkg::COS_RECIP[term_ff];
               wide = wide >> uvs_pkg::COS_SHIFT[term_ff];
               tc_in[l] = {1'b0, wide[29:0]};
               cs_in[l] = term_ff[0] ? cs_ff[l] + {1'b0, wide[29:0]}
                                     : cs_ff[l] - {1'b0, wide[29:0]};
            end
            if (term_ff == uvs_pkg::TERM_W'(uvs_pkg::TERMS - 1)) begin
               state_in = uvs_pkg::BK_NORM;
            end else begin
               term_in  = term_ff + uvs_pkg::TERM_W'(1);
               state_in = uvs_pkg::BK_MUL;
            end
         end
         uvs_pkg::BK_NORM: begin
            // theta lane 0, phi lane 1
            wide = cos_m[1] * sin_m[0];
            wide = wide + (64'd1 << 29);
            nm_in[0] = wide[60:30];
            nn_in[0] = cos_n[1] ^ sin_n[0];
            nm_in[1] = cos_m[0];
            nn_in[1] = !cos_n[0];
            wide = sin_m[1] * sin_m[0];
            wide = wide + (64'd1 << 29);
            nm_in[2] = wide[60:30];
            nn_in[2] = sin_n[1] ^ sin_n[0];
            state_in = uvs_pkg::BK_SCALE;
         end
         uvs_pkg::BK_SCALE: begin
            if (res_ready) begin
               take     = 1'b1;
               state_in = uvs_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = uvs_pkg::BK_IDLE;
         end
      endcase
      if (take && q_valid) begin
         q_ready  = 1'b1;
         item_in  = q_item;
         state_in = uvs_pkg::BK_ANGLE;
      end
   end

endmodule
`default_nettype wire

FILE: sv/uvs_emit.sv
// Result register and serializer onto the result stream.
`default_nettype none
module uvs_emit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire uvs_pkg::uvs_result_type res,
   input  wire logic                    res_valid,
   output logic                         res_ready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [135:0]                 rsp_tdata,
   output logic [1:0]                   rsp_tuser,
   output logic                         rsp_tlast
);

   uvs_pkg::uvs_result_type hold_ff;
   logic                    busy_ff;
   logic [1:0]              idx_ff;
   logic                    fire, last_step;
   logic [16:0]             cx, cy, cz, tu, tv;
   logic [15:0]             ca, cb, cc;

   assign fire      = busy_ff && rsp_tready;
   assign last_step = hold_ff.tris ? (idx_ff == uvs_pkg::OUT_TRI_B)
                                   : (idx_ff == uvs_pkg::OUT_NRM);
   assign res_ready = !busy_ff || (fire && last_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= uvs_pkg::OUT_POS;
      end else if (res_valid && res_ready) begin
         busy_ff <= 1'b1;
         idx_ff  <= uvs_pkg::OUT_POS;
      end else if (fire) begin
         if (last_step) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         hold_ff <= res;
      end
   end

   always_comb begin
      rsp_tuser = uvs_pkg::KIND_POS;
      rsp_tlast = 1'b0;
      cx = '0; cy = '0; cz = '0; tu = '0; tv = '0;
      ca = '0; cb = '0; cc = '0;
      case (idx_ff)
         uvs_pkg::OUT_POS: begin
            rsp_tuser = uvs_pkg::KIND_POS;
            cx = hold_ff.pos_x; cy = hold_ff.pos_y; cz = hold_ff.pos_z;
            tu = hold_ff.tex_u; tv = hold_ff.tex_v;
         end
         uvs_pkg::OUT_NRM: begin
            rsp_tuser = uvs_pkg::KIND_NRM;
            cx = hold_ff.nrm_x; cy = hold_ff.nrm_y; cz = hold_ff.nrm_z;
            rsp_tlast = !hold_ff.tris;
         end
         uvs_pkg::OUT_TRI_A: begin
            rsp_tuser = uvs_pkg::KIND_TRI;
            ca = hold_ff.i00; cb = hold_ff.i11; cc = hold_ff.i01;
         end
         uvs_pkg::OUT_TRI_B: begin
            rsp_tuser = uvs_pkg::KIND_TRI;
            ca = hold_ff.i11; cb = hold_ff.i00; cc = hold_ff.i10;
            rsp_tlast = 1'b1;
         end
         default: begin
            rsp_tuser = uvs_pkg::KIND_POS;
         end
      endcase
      rsp_tdata  = {3'b0, cc, cb, ca, tv, tu, cz, cy, cx};
      rsp_tvalid = busy_ff;
   end

endmodule
`default_nettype wire

FILE: sv/uv_sphere_tessellator.sv
// UV sphere tessellator top level: register port, front end, queue, back end, output.
// A grid point passes the front end, the queue, the sine/cosine series and scaling
// in the back end, and the output register. The back end takes a new grid point
// only after the last has gone on, so the six-term series loop sets the rate.
// Synchronous reset empties all stages; registers return to 16, 16 and 256.
`default_nettype none
module uv_sphere_tessellator (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [15:0]   req_tdata,   // ring_index[7:0], sector_index[15:8]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [135:0]       rsp_tdata,   // coord_x, coord_y, coord_z, tex_u, tex_v,
                                           // corner_a, corner_b, corner_c, zero pad
   output logic [1:0]         rsp_tuser,   // kind
   output logic               rsp_tlast,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [3:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [8:0]  ring_count_ff, sector_count_ff;
   logic [15:0] radius_ff;
   logic        csr_wr;

   uvs_pkg::uvs_item_type   f_item, q_item;
   logic                    f_valid, f_ready, q_valid, q_ready;
   uvs_pkg::uvs_result_type res;
   logic                    res_valid, res_ready;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff   <= 9'd16;
         sector_count_ff <= 9'd16;
         radius_ff       <= 16'd256;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            uvs_pkg::CSR_RING_COUNT:   ring_count_ff   <= csr_pwdata[8:0];
            uvs_pkg::CSR_SECTOR_COUNT: sector_count_ff <= csr_pwdata[8:0];
            uvs_pkg::CSR_RADIUS:       radius_ff       <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         uvs_pkg::CSR_RING_COUNT:   csr_prdata = {23'b0, ring_count_ff};
         uvs_pkg::CSR_SECTOR_COUNT: csr_prdata = {23'b0, sector_count_ff};
         uvs_pkg::CSR_RADIUS:       csr_prdata = {16'b0, radius_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   uvs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .ring_count   (ring_count_ff),
      .sector_count (sector_count_ff),
      .item         (f_item),
      .item_valid   (f_valid),
      .item_ready   (f_ready)
   );

   uvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (f_item),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .out_item  (q_item),
      .out_valid (q_valid),
      .out_ready (q_ready)
   );

   uvs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_item    (q_item),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .radius    (radius_ff),
      .res       (res),
      .res_valid (res_valid),
      .res_ready (res_ready)
   );

   uvs_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .res        (res),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
